FILE: design/acfr_pkg.sv
// shared types, constants and step functions for the arc center block
package acfr_pkg;

    localparam int unsigned SQ_STAGES  = 33;
    localparam int unsigned DIV_STAGES = 33;
    localparam int unsigned FRONT_LAT  = 4;
    localparam int unsigned MUL_LAT    = 2;
    localparam int unsigned LATENCY    = FRONT_LAT + SQ_STAGES + MUL_LAT + DIV_STAGES + 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    // fields that ride along the pipe with each beat
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [32:0]        adx;
        logic [32:0]        ady;
        logic               e_neg;
        t_status            status;
    } t_side;

    typedef struct packed {
        logic [65:0] rem;
        logic [32:0] root;
    } t_sq;

    typedef struct packed {
        logic [63:0] rem;
        logic [32:0] quo;
    } t_dv;

    // one digit of restoring square root
    function automatic t_sq sq_step(input logic [65:0] rem, input logic [32:0] root,
                                    input int unsigned bitpos);
        logic [66:0] term;
        t_sq         res;
        term = ({34'd0, root} << (bitpos + 1)) + (67'd1 << (2 * bitpos));
        res.rem  = rem;
        res.root = root;
        if (term <= {1'b0, rem}) begin
            res.rem  = rem - term[65:0];
            res.root = root | (33'd1 << bitpos);
        end
        return res;
    endfunction

    // one digit of restoring division
    function automatic t_dv dv_step(input logic [63:0] rem, input logic [32:0] quo,
                                    input logic [32:0] dvs, input int unsigned bitpos);
        logic [65:0] sh;
        t_dv         res;
        sh = {33'd0, dvs} << bitpos;
        res.rem = rem;
        res.quo = quo;
        if (sh <= {2'b00, rem}) begin
            res.rem = rem - sh[63:0];
            res.quo = quo | (33'd1 << bitpos);
        end
        return res;
    endfunction

endpackage

FILE: design/acfr_front.sv
// front stages: chord deltas, squares, chord and radius compare
module acfr_front import acfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_radius,
    input  logic               i_clockwise,
    output logic               o_vld,
    output logic [65:0]        o_rad,
    output logic [65:0]        o_d2,
    output t_side              o_side
);

    logic signed [32:0] dx, dy;
    logic [31:0]        ar;
    t_side              n_side1;
    t_side              n_side4;

    logic        r1_vld, r2_vld, r3_vld, r4_vld;
    t_side       r1_side, r2_side, r3_side, r4_side;
    logic [31:0] r1_ar;
    logic [64:0] r2_sqx, r2_sqy;
    logic [65:0] r2_r4, r3_r4, r3_d2, r4_d2, r4_rad;
    logic [63:0] px, py, pr;
    logic [65:0] n_d2;
    logic        short_arc;

    // stage 1: deltas and magnitudes
    always_comb begin
        dx = {i_end_x[31], i_end_x} - {i_start_x[31], i_start_x};
        dy = {i_end_y[31], i_end_y} - {i_start_y[31], i_start_y};
        ar = i_radius[31] ? 32'(-i_radius) : 32'(i_radius);
        n_side1.dx     = dx;
        n_side1.dy     = dy;
        n_side1.adx    = dx[32] ? 33'(-dx) : 33'(dx);
        n_side1.ady    = dy[32] ? 33'(-dy) : 33'(dy);
        n_side1.e_neg  = i_clockwise ^ i_radius[31];
        n_side1.status = ((i_radius == 32'sd0) || ((dx == 33'sd0) && (dy == 33'sd0)))
                       ? ST_DEGEN : ST_OK;
    end

    // stage 2: squares, a magnitude of 2^32 has an all-zero low word
    always_comb begin
        px = r1_side.adx[31:0] * r1_side.adx[31:0];
        py = r1_side.ady[31:0] * r1_side.ady[31:0];
        pr = r1_ar * r1_ar;
    end

    // stage 4: compare
    always_comb begin
        short_arc = r3_d2 > r3_r4;
        n_side4   = r3_side;
        if (short_arc && (r3_side.status == ST_OK)) begin
            n_side4.status = ST_SHORT;
        end
    end

    assign n_d2 = {1'b0, r2_sqx} + {1'b0, r2_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
        r1_side <= n_side1;
        r1_ar   <= ar;
        r2_side <= r1_side;
        r2_sqx  <= r1_side.adx[32] ? {1'b1, 64'd0} : {1'b0, px};
        r2_sqy  <= r1_side.ady[32] ? {1'b1, 64'd0} : {1'b0, py};
        r2_r4   <= {pr, 2'b00};
        r3_side <= r2_side;
        r3_d2   <= n_d2;
        r3_r4   <= r2_r4;
        r4_side <= n_side4;
        r4_d2  <= r3_d2;
        r4_rad <= short_arc ? 66'd0 : (r3_r4 - r3_d2);
    end

    assign o_vld  = r4_vld;
    assign o_rad  = r4_rad;
    assign o_d2   = r4_d2;
    assign o_side = r4_side;

endmodule

FILE: design/acfr_sqrt.sv
// pipelined restoring square root, two roots per beat, one bit per stage
module acfr_sqrt import acfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [65:0] i_rad,
    input  logic [65:0] i_d2,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [32:0] o_h,
    output logic [32:0] o_d,
    output t_side       o_side
);

    logic        r_vld    [SQ_STAGES];
    logic [65:0] r_rem_h  [SQ_STAGES];
    logic [65:0] r_rem_d  [SQ_STAGES];
    logic [32:0] r_root_h [SQ_STAGES];
    logic [32:0] r_root_d [SQ_STAGES];
    t_side       r_side   [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
        logic        vld_in;
        logic [65:0] rem_h_in, rem_d_in;
        logic [32:0] root_h_in, root_d_in;
        t_side       side_in;
        t_sq         n_h, n_d;

        if (k == 0) begin : g_first
            assign vld_in    = i_vld;
            assign rem_h_in  = i_rad;
            assign rem_d_in  = i_d2;
            assign root_h_in = '0;
            assign root_d_in = '0;
            assign side_in   = i_side;
        end else begin : g_next
            assign vld_in    = r_vld[k-1];
            assign rem_h_in  = r_rem_h[k-1];
            assign rem_d_in  = r_rem_d[k-1];
            assign root_h_in = r_root_h[k-1];
            assign root_d_in = r_root_d[k-1];
            assign side_in   = r_side[k-1];
        end

        always_comb begin
            n_h = sq_step(rem_h_in, root_h_in, SQ_STAGES - 1 - k);
            n_d = sq_step(rem_d_in, root_d_in, SQ_STAGES - 1 - k);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem_h[k]  <= n_h.rem;
            r_rem_d[k]  <= n_d.rem;
            r_root_h[k] <= n_h.root;
            r_root_d[k] <= n_d.root;
            r_side[k]   <= side_in;
        end
    end

    assign o_vld  = r_vld[SQ_STAGES-1];
    assign o_h    = r_root_h[SQ_STAGES-1];
    assign o_d    = r_root_d[SQ_STAGES-1];
    assign o_side = r_side[SQ_STAGES-1];

endmodule

FILE: design/acfr_div.sv
// pipelined restoring divider, two quotients over a shared divisor
module acfr_div import acfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_ni,
    input  logic [63:0] i_nj,
    input  logic [32:0] i_dvs,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [32:0] o_qi,
    output logic [32:0] o_qj,
    output t_side       o_side
);

    logic        r_vld   [DIV_STAGES];
    logic [63:0] r_rem_i [DIV_STAGES];
    logic [63:0] r_rem_j [DIV_STAGES];
    logic [32:0] r_q_i   [DIV_STAGES];
    logic [32:0] r_q_j   [DIV_STAGES];
    logic [32:0] r_dvs   [DIV_STAGES];
    t_side       r_side  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
        logic        vld_in;
        logic [63:0] rem_i_in, rem_j_in;
        logic [32:0] q_i_in, q_j_in, dvs_in;
        t_side       side_in;
        t_dv         n_i, n_j;

        if (k == 0) begin : g_first
            assign vld_in   = i_vld;
            assign rem_i_in = i_ni;
            assign rem_j_in = i_nj;
            assign q_i_in   = '0;
            assign q_j_in   = '0;
            assign dvs_in   = i_dvs;
            assign side_in  = i_side;
        end else begin : g_next
            assign vld_in   = r_vld[k-1];
            assign rem_i_in = r_rem_i[k-1];
            assign rem_j_in = r_rem_j[k-1];
            assign q_i_in   = r_q_i[k-1];
            assign q_j_in   = r_q_j[k-1];
            assign dvs_in   = r_dvs[k-1];
            assign side_in  = r_side[k-1];
        end

        always_comb begin
            n_i = dv_step(rem_i_in, q_i_in, dvs_in, DIV_STAGES - 1 - k);
            n_j = dv_step(rem_j_in, q_j_in, dvs_in, DIV_STAGES - 1 - k);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
            r_rem_i[k] <= n_i.rem;
            r_rem_j[k] <= n_j.rem;
            r_q_i[k]   <= n_i.quo;
            r_q_j[k]   <= n_j.quo;
            r_dvs[k]   <= dvs_in;
            r_side[k]  <= side_in;
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_qi   = r_q_i[DIV_STAGES-1];
    assign o_qj   = r_q_j[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

endmodule

FILE: design/arc_center_from_radius_core.sv
// arc center offset from radius: top level with multiply and output stages
// an accepted start passes the front, root, scale, divider and output registers to o_valid
// throughput: one command per cycle, busy never rises
// depth is set by the one-bit-per-stage square root (33) and divider (33) pipes
// reset: synchronous active low, clears every stage valid bit; data regs not reset
// the result beat is shown for one cycle and cannot be held off by the receiver
module arc_center_from_radius_core import acfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_radius,
    input  logic               i_clockwise,
    output logic               o_valid,
    output logic signed [31:0] o_offset_i,
    output logic signed [31:0] o_offset_j,
    output logic [1:0]         o_status
);

    // front: deltas, squares, d2 and (2r)^2, radicand clamp
    logic        f_vld;
    logic [65:0] f_rad, f_d2;
    t_side       f_side;

    // root pipe outputs: H = 2h and D = chord length
    logic        s_vld;
    logic [32:0] s_h, s_d;
    t_side       s_side;

    // scale stage: H*|dy| and H*|dx|, then add D/2 for rounding
    logic        r_m1_vld, r_m2_vld;
    logic [63:0] r_m1_pi, r_m1_pj, r_m2_ni, r_m2_nj;
    logic [32:0] r_m1_dvs, r_m2_dvs;
    t_side       r_m1_side, r_m2_side;
    logic [63:0] n_pi, n_pj;

    // divider outputs
    logic        d_vld;
    logic [32:0] d_qi, d_qj;
    t_side       d_side;

    // output stage
    logic signed [34:0] sum_i, sum_j, half_i, half_j;
    logic signed [31:0] n_off_i, n_off_j;
    logic               r_out_vld;
    logic signed [31:0] r_off_i, r_off_j;
    t_status            r_status;

    assign busy = 1'b0;

    acfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (start),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_radius    (i_radius),
        .i_clockwise (i_clockwise),
        .o_vld       (f_vld),
        .o_rad       (f_rad),
        .o_d2        (f_d2),
        .o_side      (f_side)
    );

    acfr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (f_vld),
        .i_rad   (f_rad),
        .i_d2    (f_d2),
        .i_side  (f_side),
        .o_vld   (s_vld),
        .o_h     (s_h),
        .o_d     (s_d),
        .o_side  (s_side)
    );

    // 33-bit operands: a value of 2^32 has a zero low word, so a shift covers it
    always_comb begin
        if (s_h[32]) begin
            n_pi = {s_side.ady[31:0], 32'd0};
            n_pj = {s_side.adx[31:0], 32'd0};
        end else begin
            n_pi = s_side.ady[32] ? {s_h[31:0], 32'd0} : s_h[31:0] * s_side.ady[31:0];
            n_pj = s_side.adx[32] ? {s_h[31:0], 32'd0} : s_h[31:0] * s_side.adx[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
        end else begin
            r_m1_vld <= s_vld;
            r_m2_vld <= r_m1_vld;
        end
        r_m1_pi   <= n_pi;
        r_m1_pj   <= n_pj;
        r_m1_dvs  <= (s_d == 33'd0) ? 33'd1 : s_d;
        r_m1_side <= s_side;
        // round to nearest by adding half the divisor
        r_m2_ni   <= r_m1_pi + {32'd0, r_m1_dvs[32:1]};
        r_m2_nj   <= r_m1_pj + {32'd0, r_m1_dvs[32:1]};
        r_m2_dvs  <= r_m1_dvs;
        r_m2_side <= r_m1_side;
    end

    acfr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m2_vld),
        .i_ni    (r_m2_ni),
        .i_nj    (r_m2_nj),
        .i_dvs   (r_m2_dvs),
        .i_side  (r_m2_side),
        .o_vld   (d_vld),
        .o_qi    (d_qi),
        .o_qj    (d_qj),
        .o_side  (d_side)
    );

    // side of the chord: e is negative for clockwise xor negative radius
    always_comb begin
        if (d_side.e_neg ^ d_side.dy[32]) begin
            sum_i = 35'(d_side.dx) + $signed({2'b00, d_qi});
        end else begin
            sum_i = 35'(d_side.dx) - $signed({2'b00, d_qi});
        end
        if (d_side.e_neg ^ d_side.dx[32]) begin
            sum_j = 35'(d_side.dy) - $signed({2'b00, d_qj});
        end else begin
            sum_j = 35'(d_side.dy) + $signed({2'b00, d_qj});
        end
        half_i = sum_i >>> 1;
        half_j = sum_j >>> 1;

        if (half_i > 35'sd2147483647) begin
            n_off_i = 32'sh7fffffff;
        end else if (half_i < -35'sd2147483648) begin
            n_off_i = 32'sh80000000;
        end else begin
            n_off_i = half_i[31:0];
        end
        if (half_j > 35'sd2147483647) begin
            n_off_j = 32'sh7fffffff;
        end else if (half_j < -35'sd2147483648) begin
            n_off_j = 32'sh80000000;
        end else begin
            n_off_j = half_j[31:0];
        end

        case (d_side.status)
            ST_DEGEN: begin
                n_off_i = '0;
                n_off_j = '0;
            end
            ST_SHORT: begin
                // clamped radicand: center at the chord midpoint
                n_off_i = d_side.dx[32:1];
                n_off_j = d_side.dy[32:1];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= d_vld;
        end
        r_off_i  <= n_off_i;
        r_off_j  <= n_off_j;
        r_status <= d_side.status;
    end

    assign o_valid    = r_out_vld;
    assign o_offset_i = r_off_i;
    assign o_offset_j = r_off_j;
    assign o_status   = r_status;

    // every accepted beat comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("result beat missing after latency");

    // no result beat without a command that latency ago
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result beat without a command");

    // degenerate arcs put the center on the start point
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DEGEN)) |-> ((o_offset_i == 32'sd0) && (o_offset_j == 32'sd0)))
        else $error("degenerate arc with nonzero offset");

endmodule

FILE: tb/arc_center_checker.sv
// checker for the arc center block: predicts the center offset per beat and compares
`timescale 1ns / 100ps
module arc_center_checker import acfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_radius,
    input  logic               i_clockwise,
    input  logic               o_valid,
    input  logic signed [31:0] o_offset_i,
    input  logic signed [31:0] o_offset_j,
    input  logic [1:0]         o_status,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic signed [31:0] off_i;
        logic signed [31:0] off_j;
        t_status            status;
    } t_offset;

    t_offset pending_offsets[$];

    function automatic logic [67:0] isqrt(input logic [67:0] v);
        logic [67:0] res;
        logic [67:0] cand;
        res = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = res | (68'd1 << b);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] halve_sat(input logic signed [67:0] n);
        logic signed [67:0] h;
        h = n >>> 1;
        if (h > 68'sd2147483647) return 32'sh7fffffff;
        if (h < -68'sd2147483648) return 32'sh80000000;
        return h[31:0];
    endfunction

    function automatic t_offset center_offset(input logic signed [31:0] sx, sy, ex, ey, rad,
                                              input logic cw);
        logic signed [67:0] dx, dy, ni, nj;
        logic [67:0]        adx, ady, two_r, d2, r4, hh, dd, qi, qj;
        logic               e_neg;
        t_offset            res;
        dx = 68'(ex) - 68'(sx);
        dy = 68'(ey) - 68'(sy);
        if (rad == 0 || (dx == 0 && dy == 0)) begin
            res.off_i = '0; res.off_j = '0; res.status = ST_DEGEN;
            return res;
        end
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        two_r = 68'(rad < 0 ? -68'(rad) : 68'(rad)) << 1;
        d2 = adx * adx + ady * ady;
        r4 = two_r * two_r;
        if (d2 > r4) begin
            res.off_i = halve_sat(dx); res.off_j = halve_sat(dy); res.status = ST_SHORT;
            return res;
        end
        hh = isqrt(r4 - d2);
        dd = isqrt(d2);
        if (dd == 0) dd = 1;
        qi = (hh * ady + (dd >> 1)) / dd;
        qj = (hh * adx + (dd >> 1)) / dd;
        // side flips with direction xor negative radius
        e_neg = cw ^ (rad < 0);
        ni = dx - ((e_neg ^ (dy < 0)) ? -$signed(qi) : $signed(qi));
        nj = dy + ((e_neg ^ (dx < 0)) ? -$signed(qj) : $signed(qj));
        res.off_i = halve_sat(ni); res.off_j = halve_sat(nj); res.status = ST_OK;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_offset want;
        if (!i_rst_n) begin
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (start && !busy)
                pending_offsets.push_back(center_offset(i_start_x, i_start_y, i_end_x,
                                                        i_end_y, i_radius, i_clockwise));
            if (o_valid) begin
                if (pending_offsets.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat at %0t", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    want = pending_offsets.pop_front();
                    if (o_offset_i !== want.off_i || o_offset_j !== want.off_j
                        || o_status !== want.status) begin
                        if (fail_count < 10)
                            $display("mismatch: exp i=%0d j=%0d st=%0d got i=%0d j=%0d st=%0d",
                                     want.off_i, want.off_j, want.status,
                                     o_offset_i, o_offset_j, o_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= pending_offsets.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// stimulus and verdict for the arc center block
`timescale 1ns / 100ps
module testbench;
    import acfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, o_valid;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_end_x = '0, i_end_y = '0;
    logic signed [31:0] i_radius = '0;
    logic i_clockwise = 1'b0;
    logic signed [31:0] o_offset_i, o_offset_j;
    logic [1:0] o_status;
    int fail_count, pending_count;
    int idle_cycles = 0;
    int send_idle_pct = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    arc_center_from_radius_core u_dut (.*);

    arc_center_checker u_chk (.*);

    // watchdog: cycles with no beat accepted on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(0, 4000)) - 2000;
            default: return $urandom();
        endcase
    endfunction

    // present one command and hold it until accepted; random gaps before it
    task automatic send_arc(input logic signed [31:0] sx, sy, ex, ey, rad, input logic cw);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        i_radius <= rad; i_clockwise <= cw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic signed [31:0] sx, sy, ex, ey, rad;
        for (int n = 0; n < count; n++) begin
            sx = rand_coord(); sy = rand_coord();
            case ($urandom_range(0, 3))
                // nearby end point with a radius near the half chord: reaches the root path
                0, 1: begin
                    ex = sx + $signed($urandom_range(0, 200000)) - 100000;
                    ey = sy + $signed($urandom_range(0, 200000)) - 100000;
                    rad = $signed($urandom_range(0, 160000));
                    if ($urandom_range(0, 1)) rad = -rad;
                end
                2: begin ex = rand_coord(); ey = rand_coord(); rad = rand_coord(); end
                default: begin ex = sx; ey = sy; rad = $urandom(); end
            endcase
            send_arc(sx, sy, ex, ey, rad, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: quarter and half circles, both sides, degenerate and short cases
        send_arc(0, 0, 32'sd131072, 0, 32'sd65536, 1'b0);
        send_arc(0, 0, 32'sd131072, 0, 32'sd65536, 1'b1);
        send_arc(0, 0, 32'sd65536, 32'sd65536, 32'sd65536, 1'b0);
        send_arc(0, 0, 32'sd65536, 32'sd65536, -32'sd65536, 1'b0);
        send_arc(0, 0, 32'sd65536, -32'sd65536, 32'sd65536, 1'b1);
        send_arc(0, 0, -32'sd65536, -32'sd65536, -32'sd65536, 1'b1);
        send_arc(100, 200, 300, 400, 0, 1'b0);
        send_arc(5, 5, 5, 5, 32'sd1000, 1'b1);
        send_arc(0, 0, 32'sd1000, 0, 32'sd10, 1'b0);
        send_arc(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 1'b0);
        send_arc(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 1'b1);
        send_arc(32'sh80000000, 0, 32'sh7fffffff, 0, 32'sh80000000, 1'b0);
        send_arc(0, 32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff, 1'b1);
        send_arc(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1, 1'b0);
        send_arc(32'shffffffff, 32'shffffffff, 0, 0, 32'shffffffff, 1'b1);
        send_arc(0, 0, 32'sh7fffffff, 0, 32'sh7fffffff, 1'b0);
        send_arc(0, 0, 3, 4, 32'sd3, 1'b1);

        // random phases: sender idles sometimes, then often, then never
        send_idle_pct = 27; send_random(200);
        send_idle_pct = 79; send_random(200);
        send_idle_pct = 0;  send_random(200);
        start <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
